// File: sv/dke_pkg.sv
// shared types and constants of the debounced keypad encoder
// used by dke_keymap, dke_core and debounced_keypad_encoder; no dependencies
package dke_pkg;

  localparam int unsigned NUM_KEYS   = 8;
  localparam int unsigned CODE_W     = 4;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned TABLE_W    = NUM_KEYS * CODE_W;

  // frames a level must hold before it counts as settled
  localparam logic [CNT_W:0] STABLE_FRAMES = 3'd3;

  localparam logic [NUM_KEYS-1:0] IDLE_SAMPLE      = 8'hFF;
  localparam logic [NUM_KEYS-1:0] CHORD_MASK_RESET = 8'h12;

  typedef enum logic [1:0] {
    PH_PRESS   = 2'd0,
    PH_RELEASE = 2'd1,
    PH_CHORD   = 2'd2
  } phase_e;

  typedef enum logic {
    EV_KEY   = 1'b0,
    EV_RESET = 1'b1
  } event_kind_e;

  typedef enum logic {
    CFG_KEY_TABLE  = 1'b0,
    CFG_CHORD_MASK = 1'b1
  } cfg_index_e;

  // result of one processed sample
  typedef struct packed {
    logic               emit;
    event_kind_e        kind;
    logic [CODE_W-1:0]  code;
  } event_t;

endpackage

// File: sv/dke_keymap.sv
// key lookup: highest pressed button to key code, and lowest table slot with that code
// depends on dke_pkg
module dke_keymap (
  input  logic [dke_pkg::NUM_KEYS-1:0] sample_i,
  input  logic [dke_pkg::TABLE_W-1:0]  key_table_i,
  output logic [dke_pkg::CODE_W-1:0]   code_o,
  output logic [dke_pkg::IDX_W-1:0]    watch_idx_o
);

  logic [dke_pkg::CODE_W-1:0] entry [dke_pkg::NUM_KEYS];
  logic [dke_pkg::IDX_W-1:0]  top_idx;

  always_comb begin
    for (int i = 0; i < dke_pkg::NUM_KEYS; i++) begin
      entry[i] = key_table_i[i*dke_pkg::CODE_W +: dke_pkg::CODE_W];
    end
  end

  // highest low bit wins, index 0 when nothing is pressed
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < dke_pkg::NUM_KEYS; i++) begin
      if (!sample_i[i]) begin
        top_idx = dke_pkg::IDX_W'(i);
      end
    end
  end

  assign code_o = entry[top_idx];

  // descending scan leaves the lowest match
  always_comb begin
    watch_idx_o = '0;
    for (int i = dke_pkg::NUM_KEYS - 1; i >= 0; i--) begin
      if (entry[i] == code_o) begin
        watch_idx_o = dke_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// File: sv/dke_core.sv
// debounce state machine: press counting, release watch and chord wait
// depends on dke_pkg and dke_keymap
module dke_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic [dke_pkg::NUM_KEYS-1:0]  sample_i,
  input  logic [dke_pkg::TABLE_W-1:0]   key_table_i,
  input  logic [dke_pkg::NUM_KEYS-1:0]  chord_mask_i,
  output dke_pkg::event_t               event_o
);

  dke_pkg::phase_e               phase_q, phase_d;
  logic [dke_pkg::NUM_KEYS-1:0]  last_sample_q, last_sample_d;
  logic [dke_pkg::CNT_W-1:0]     stable_cnt_q, stable_cnt_d;
  logic [dke_pkg::IDX_W-1:0]     watch_idx_q, watch_idx_d;
  logic [dke_pkg::CODE_W-1:0]    held_key_q, held_key_d;

  logic [dke_pkg::CODE_W-1:0]    map_code;
  logic [dke_pkg::IDX_W-1:0]     map_idx;
  logic [dke_pkg::CNT_W:0]       cnt_nx;

  dke_keymap u_keymap (
    .sample_i    (sample_i),
    .key_table_i (key_table_i),
    .code_o      (map_code),
    .watch_idx_o (map_idx)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= dke_pkg::PH_PRESS;
      last_sample_q <= dke_pkg::IDLE_SAMPLE;
      stable_cnt_q  <= '0;
      watch_idx_q   <= '0;
      held_key_q    <= '0;
    end else begin
      phase_q       <= phase_d;
      last_sample_q <= last_sample_d;
      stable_cnt_q  <= stable_cnt_d;
      watch_idx_q   <= watch_idx_d;
      held_key_q    <= held_key_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    last_sample_d = last_sample_q;
    stable_cnt_d  = stable_cnt_q;
    watch_idx_d   = watch_idx_q;
    held_key_d    = held_key_q;
    event_o       = '{emit: 1'b0, kind: dke_pkg::EV_KEY, code: '0};
    cnt_nx        = {1'b0, stable_cnt_q};

    if (adv_i) begin
      if (phase_q == dke_pkg::PH_CHORD || (sample_i & chord_mask_i) == '0) begin
        // chord held: wait for full release, then back to reset state
        if (sample_i == dke_pkg::IDLE_SAMPLE) begin
          phase_d       = dke_pkg::PH_PRESS;
          last_sample_d = dke_pkg::IDLE_SAMPLE;
          stable_cnt_d  = '0;
          watch_idx_d   = '0;
          held_key_d    = '0;
          event_o       = '{emit: 1'b1, kind: dke_pkg::EV_RESET, code: '0};
        end else begin
          phase_d = dke_pkg::PH_CHORD;
        end
      end else begin
        case (phase_q)
          dke_pkg::PH_RELEASE: begin
            cnt_nx = sample_i[watch_idx_q] ? ({1'b0, stable_cnt_q} + 1'b1) : '0;
            if (cnt_nx >= dke_pkg::STABLE_FRAMES) begin
              event_o       = '{emit: 1'b1, kind: dke_pkg::EV_KEY, code: held_key_q};
              phase_d       = dke_pkg::PH_PRESS;
              stable_cnt_d  = '0;
              last_sample_d = sample_i;
            end else begin
              stable_cnt_d = cnt_nx[dke_pkg::CNT_W-1:0];
            end
          end
          default: begin
            // press phase; an unchanged idle sample leaves the count alone
            if (sample_i != last_sample_q) begin
              cnt_nx        = '0;
              last_sample_d = sample_i;
            end else if (sample_i != dke_pkg::IDLE_SAMPLE) begin
              cnt_nx = {1'b0, stable_cnt_q} + 1'b1;
            end
            if (cnt_nx >= dke_pkg::STABLE_FRAMES) begin
              held_key_d   = map_code;
              watch_idx_d  = map_idx;
              stable_cnt_d = '0;
              phase_d      = dke_pkg::PH_RELEASE;
            end else begin
              stable_cnt_d = cnt_nx[dke_pkg::CNT_W-1:0];
            end
          end
        endcase
      end
    end
  end

endmodule

// File: sv/debounced_keypad_encoder.sv
// top level of the debounced keypad encoder: stream ports, config registers,
// input and result registers; depends on dke_pkg, dke_core and dke_keymap
//
// usage
//   s_axis carries one request per frame: an 8-bit button sample, active low
//   (bit clear = pressed). m_axis carries events: tuser is the kind (key
//   pressed and released, or reset request) and tdata[3:0] the key code,
//   zero for a reset request.
//   the cfg channel writes the key table (index 0, eight 4-bit codes) and
//   the chord mask (index 1); cfg_ready_o is always high. write only while
//   no sample is in flight.
//   order: a sample is registered on acceptance and evaluated once the result
//   register is free; an event it causes is registered, then shows on m_axis.
//   throughput: one sample per cycle while no event is stalled on m_axis; the
//   only loop is the registered debounce state update in dke_core.
//   most samples cause no event; only debounced key releases and chord
//   releases do.
//   reset: phase back to press, last sample all released, counters and the
//   key table cleared, chord mask set to buttons 1 and 4.
//   stall: while m_axis_tready is low and an event waits, the input
//   register holds one more sample, then s_axis_tready drops.
module debounced_keypad_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] sample
  // event stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [3:0] key_code, [7:4] zero
  output logic                          m_axis_tuser,   // [0] event_kind
  // config writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [31:0]                   cfg_data_i
);

  // config registers
  logic [dke_pkg::TABLE_W-1:0]   key_table_q;
  logic [dke_pkg::NUM_KEYS-1:0]  chord_mask_q;

  // input register
  logic                          in_vld_q;
  logic [dke_pkg::NUM_KEYS-1:0]  sample_q;

  // result register
  logic                          out_vld_q, out_vld_d;
  dke_pkg::event_kind_e          out_kind_q;
  logic [dke_pkg::CODE_W-1:0]    out_code_q;

  logic                          out_free;
  logic                          adv;
  logic                          in_take;
  dke_pkg::event_t               ev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_table_q  <= '0;
      chord_mask_q <= dke_pkg::CHORD_MASK_RESET;
    end else if (cfg_valid_i) begin
      case (dke_pkg::cfg_index_e'(cfg_index_i))
        dke_pkg::CFG_KEY_TABLE:  key_table_q  <= cfg_data_i;
        dke_pkg::CFG_CHORD_MASK: chord_mask_q <= cfg_data_i[dke_pkg::NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  // a held sample moves on when the result register is empty or being drained
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata;
    end
  end

  dke_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .sample_i     (sample_q),
    .key_table_i  (key_table_q),
    .chord_mask_i (chord_mask_q),
    .event_o      (ev)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = adv && ev.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && ev.emit) begin
      out_kind_q <= ev.kind;
      out_code_q <= ev.code;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(8 - dke_pkg::CODE_W){1'b0}}, out_code_q};
  assign m_axis_tuser  = out_kind_q;

  // a reset request never carries a key code
  a_reset_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == dke_pkg::EV_RESET) |-> (m_axis_tdata == '0))
    else $error("reset request with nonzero key code");

  // an empty result register must never block the sample stream
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("sample stream stalled with empty result register");

  // a held sample only waits behind a stalled event
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |-> (out_vld_q && !m_axis_tready))
    else $error("held sample not advancing without downstream stall");

  // an event only appears after a sample was evaluated
  a_event_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(adv))
    else $error("event without evaluated sample");

endmodule
